@@ rtl/art_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// art_pkg: shared types and constants of the address region table
// Entry, request and response layouts, request and status codes, FSM states.
// ----------------------------------------------------------------------------
package art_pkg;

    localparam int ADDR_W  = 48;
    localparam int FLAGS_W = 8;
    localparam int COUNT_W = 7;

    // reset values of the configuration registers
    localparam logic [ADDR_W-1:0]  BASE_RESET  = 48'h0000_0040_0000;
    localparam logic [ADDR_W-1:0]  LIMIT_RESET = 48'h8000_0000_0000;
    localparam logic [FLAGS_W-1:0] FLAGS_RESET = 8'h00;

    // configuration register indexes
    localparam logic [1:0] CFG_REGION_BASE  = 2'd0;
    localparam logic [1:0] CFG_REGION_LIMIT = 2'd1;
    localparam logic [1:0] CFG_BOOT_FLAGS   = 2'd2;

    // request types
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_ADD   = 2'd2;

    // response status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_NOGAP   = 2'd2;
    localparam logic [1:0] STATUS_FULL    = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]  start_addr;
        logic [ADDR_W-1:0]  end_addr;
        logic [FLAGS_W-1:0] flags;
    } entry_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [ADDR_W-1:0]  range_start;
        logic [ADDR_W-1:0]  range_end;
        logic [ADDR_W-1:0]  alloc_size;
        logic [FLAGS_W-1:0] region_flags;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ADDR_W-1:0]  result_address;
        logic [COUNT_W-1:0] region_count;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_DONE
    } state_t;

    // outcome of one scan step
    typedef enum logic [1:0] {
        ACT_NEXT,
        ACT_FINISH,
        ACT_INSERT,
        ACT_DELETE
    } act_t;

    // boot entry present after reset
    localparam entry_t BOOT_ENTRY = '{start_addr: BASE_RESET, end_addr: BASE_RESET,
                                      flags: FLAGS_RESET};

endpackage
`default_nettype wire

@@ rtl/art_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// art_mem: region entry memory
// One write and one registered read port. Entry 0 reads as the boot entry
// until it is first written.
// ----------------------------------------------------------------------------
module art_mem #(
    parameter int DEPTH = 64
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          wr_en,
    input  wire [$clog2(DEPTH)-1:0]      wr_addr,
    input  art_pkg::entry_t              wr_data,
    input  wire [$clog2(DEPTH)-1:0]      rd_addr,
    output art_pkg::entry_t              rd_data
);

    localparam int IDX_W = $clog2(DEPTH);

    art_pkg::entry_t mem [DEPTH];
    art_pkg::entry_t q_reg;
    logic            boot_pending_reg;
    logic            rd_boot_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        q_reg <= mem[rd_addr];
    end

    // track whether entry 0 still holds the boot entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boot_pending_reg <= 1'b1;
            rd_boot_reg      <= 1'b0;
        end else begin
            rd_boot_reg <= boot_pending_reg && (rd_addr == IDX_W'(0));
            if (wr_en && (wr_addr == IDX_W'(0))) begin
                boot_pending_reg <= 1'b0;
            end
        end
    end

    assign rd_data = rd_boot_reg ? art_pkg::BOOT_ENTRY : q_reg;

endmodule
`default_nettype wire

@@ rtl/art_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// art_ctrl: request sequencer of the address region table
// Scans the sorted entries one per cycle, then grows or trims an entry in
// place, or inserts or deletes by shifting entries through the memory.
// ----------------------------------------------------------------------------
module art_ctrl #(
    parameter int MAX_REGIONS = 64
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire [art_pkg::ADDR_W-1:0]         region_base,
    input  wire [art_pkg::ADDR_W-1:0]         region_limit,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  art_pkg::req_t                     s_data,
    output logic                              m_valid,
    input  wire                               m_ready,
    output art_pkg::rsp_t                     m_data,
    output logic                              mem_wr_en,
    output logic [$clog2(MAX_REGIONS)-1:0]    mem_wr_addr,
    output art_pkg::entry_t                   mem_wr_data,
    output logic [$clog2(MAX_REGIONS)-1:0]    mem_rd_addr,
    input  art_pkg::entry_t                   mem_rd_data
);

    localparam int IDX_W  = $clog2(MAX_REGIONS);
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
    localparam int ADDR_W = art_pkg::ADDR_W;

    art_pkg::state_t state_reg, state_next;
    art_pkg::req_t   req_reg, req_next;
    art_pkg::entry_t prev_reg, prev_next;
    art_pkg::entry_t ins_reg, ins_next;
    art_pkg::rsp_t   m_data_reg, m_data_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [1:0]        status_reg, status_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              m_valid_reg, m_valid_next;

    // scan step outcome
    art_pkg::act_t     ev_act;
    logic [1:0]        ev_status;
    logic [ADDR_W-1:0] ev_addr;
    logic              ev_wr;
    logic [IDX_W-1:0]  ev_wr_addr;
    art_pkg::entry_t   ev_wr_entry;
    logic [CNT_W-1:0]  ev_ins_pos;
    art_pkg::entry_t   ev_ins_entry;

    logic accept;
    logic out_free;
    logic full;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign full     = count_reg >= CNT_W'(MAX_REGIONS);
    assign s_ready  = (state_reg == art_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // evaluate the gap or entry at the current scan position
    always_comb begin : scan_eval
        logic [ADDR_W:0]   sum;
        logic [ADDR_W-1:0] gs;
        logic [ADDR_W-1:0] ge;
        logic              at_top;
        logic              fit;
        logic              below_ok;
        logic              above_ok;
        logic              bad_range;
        at_top    = (cur_reg == count_reg);
        gs        = (cur_reg == CNT_W'(0)) ? region_base : prev_reg.end_addr;
        ge        = at_top ? region_limit : mem_rd_data.start_addr;
        sum       = {1'b0, gs} + {1'b0, req_reg.alloc_size};
        fit       = !sum[ADDR_W] && (sum[ADDR_W-1:0] < ge) && (gs >= region_base)
                    && (sum[ADDR_W-1:0] < region_limit);
        below_ok  = (cur_reg == CNT_W'(0)) || (prev_reg.end_addr <= req_reg.range_start);
        above_ok  = at_top || (mem_rd_data.start_addr >= req_reg.range_end);
        bad_range = req_reg.range_start >= req_reg.range_end;

        ev_act       = art_pkg::ACT_NEXT;
        ev_status    = art_pkg::STATUS_OK;
        ev_addr      = '0;
        ev_wr        = 1'b0;
        ev_wr_addr   = IDX_W'(cur_reg);
        ev_wr_entry  = mem_rd_data;
        ev_ins_pos   = cur_reg;
        ev_ins_entry = '{start_addr: req_reg.range_start, end_addr: req_reg.range_end,
                         flags: req_reg.region_flags};

        unique case (req_reg.req_type)
            art_pkg::REQ_ALLOC: begin
                if (fit) begin
                    if ((cur_reg != CNT_W'(0)) && (prev_reg.flags == req_reg.region_flags)) begin
                        // grow the entry just below the gap
                        ev_act               = art_pkg::ACT_FINISH;
                        ev_wr                = 1'b1;
                        ev_wr_addr           = IDX_W'(cur_reg - CNT_W'(1));
                        ev_wr_entry          = prev_reg;
                        ev_wr_entry.end_addr = sum[ADDR_W-1:0];
                        ev_addr              = gs;
                    end else if (full) begin
                        ev_act    = art_pkg::ACT_FINISH;
                        ev_status = art_pkg::STATUS_FULL;
                    end else begin
                        ev_act       = art_pkg::ACT_INSERT;
                        ev_addr      = gs;
                        ev_ins_entry = '{start_addr: gs, end_addr: sum[ADDR_W-1:0],
                                         flags: req_reg.region_flags};
                    end
                end else if (at_top) begin
                    ev_act    = art_pkg::ACT_FINISH;
                    ev_status = art_pkg::STATUS_NOGAP;
                end
            end
            art_pkg::REQ_FREE: begin
                if (bad_range || at_top) begin
                    ev_act    = art_pkg::ACT_FINISH;
                    ev_status = art_pkg::STATUS_INVALID;
                end else if ((req_reg.range_start >= mem_rd_data.start_addr)
                             && (req_reg.range_end <= mem_rd_data.end_addr)) begin
                    priority if ((req_reg.range_start == mem_rd_data.start_addr)
                                 && (req_reg.range_end == mem_rd_data.end_addr)) begin
                        ev_act = art_pkg::ACT_DELETE;
                    end else if (req_reg.range_start == mem_rd_data.start_addr) begin
                        ev_act                 = art_pkg::ACT_FINISH;
                        ev_wr                  = 1'b1;
                        ev_wr_entry.start_addr = req_reg.range_end;
                    end else if (req_reg.range_end == mem_rd_data.end_addr) begin
                        ev_act               = art_pkg::ACT_FINISH;
                        ev_wr                = 1'b1;
                        ev_wr_entry.end_addr = req_reg.range_start;
                    end else if (full) begin
                        ev_act    = art_pkg::ACT_FINISH;
                        ev_status = art_pkg::STATUS_FULL;
                    end else begin
                        // split: trim this entry now, insert the upper part above it
                        ev_act               = art_pkg::ACT_INSERT;
                        ev_wr                = 1'b1;
                        ev_wr_entry.end_addr = req_reg.range_start;
                        ev_ins_pos           = cur_reg + CNT_W'(1);
                        ev_ins_entry         = '{start_addr: req_reg.range_end,
                                                 end_addr: mem_rd_data.end_addr,
                                                 flags: mem_rd_data.flags};
                    end
                end
            end
            art_pkg::REQ_ADD: begin
                if (bad_range) begin
                    ev_act    = art_pkg::ACT_FINISH;
                    ev_status = art_pkg::STATUS_INVALID;
                end else if (below_ok && above_ok) begin
                    if (full) begin
                        ev_act    = art_pkg::ACT_FINISH;
                        ev_status = art_pkg::STATUS_FULL;
                    end else begin
                        ev_act = art_pkg::ACT_INSERT;
                    end
                end else if (at_top) begin
                    ev_act    = art_pkg::ACT_FINISH;
                    ev_status = art_pkg::STATUS_INVALID;
                end
            end
            default: begin
                ev_act    = art_pkg::ACT_FINISH;
                ev_status = art_pkg::STATUS_INVALID;
            end
        endcase
    end

    // next state
    always_comb begin : fsm_next
        state_next = state_reg;
        unique case (state_reg)
            art_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = art_pkg::ST_SCAN;
                end
            end
            art_pkg::ST_SCAN: begin
                unique case (ev_act)
                    art_pkg::ACT_NEXT:   state_next = art_pkg::ST_SCAN;
                    art_pkg::ACT_FINISH: state_next = art_pkg::ST_DONE;
                    art_pkg::ACT_INSERT: state_next = art_pkg::ST_SHIFT_UP;
                    art_pkg::ACT_DELETE: state_next = art_pkg::ST_SHIFT_DN;
                    default:             state_next = art_pkg::ST_DONE;
                endcase
            end
            art_pkg::ST_SHIFT_UP: begin
                if (k_reg == pos_reg) begin
                    state_next = art_pkg::ST_DONE;
                end
            end
            art_pkg::ST_SHIFT_DN: begin
                if ((k_reg + CNT_W'(1)) >= count_reg) begin
                    state_next = art_pkg::ST_DONE;
                end
            end
            art_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = art_pkg::ST_IDLE;
                end
            end
            default: state_next = art_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin : fsm_out
        req_next     = req_reg;
        prev_next    = prev_reg;
        ins_next     = ins_reg;
        cur_next     = cur_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        pos_next     = pos_reg;
        status_next  = status_reg;
        addr_next    = addr_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = IDX_W'(cur_reg);
        mem_wr_data  = mem_rd_data;
        mem_rd_addr  = '0;

        unique case (state_reg)
            art_pkg::ST_IDLE: begin
                // latch the request, read entry 0
                if (accept) begin
                    req_next = s_data;
                    cur_next = '0;
                end
            end
            art_pkg::ST_SCAN: begin
                mem_rd_addr = IDX_W'(cur_reg + CNT_W'(1));
                mem_wr_en   = ev_wr;
                mem_wr_addr = ev_wr_addr;
                mem_wr_data = ev_wr_entry;
                status_next = ev_status;
                addr_next   = ev_addr;
                unique case (ev_act)
                    art_pkg::ACT_NEXT: begin
                        prev_next = mem_rd_data;
                        cur_next  = cur_reg + CNT_W'(1);
                    end
                    art_pkg::ACT_INSERT: begin
                        mem_rd_addr = IDX_W'(count_reg - CNT_W'(1));
                        k_next      = count_reg;
                        pos_next    = ev_ins_pos;
                        ins_next    = ev_ins_entry;
                    end
                    art_pkg::ACT_DELETE: begin
                        mem_rd_addr = IDX_W'(cur_reg + CNT_W'(1));
                        k_next      = cur_reg;
                    end
                    default: begin
                    end
                endcase
            end
            art_pkg::ST_SHIFT_UP: begin
                // move entries up one slot from the top, then drop the new one in
                mem_wr_en   = 1'b1;
                mem_wr_addr = IDX_W'(k_reg);
                if (k_reg == pos_reg) begin
                    mem_wr_data = ins_reg;
                    count_next  = count_reg + CNT_W'(1);
                end else begin
                    mem_wr_data = mem_rd_data;
                    mem_rd_addr = IDX_W'(k_reg - CNT_W'(2));
                    k_next      = k_reg - CNT_W'(1);
                end
            end
            art_pkg::ST_SHIFT_DN: begin
                // move entries down one slot over the deleted one
                if ((k_reg + CNT_W'(1)) >= count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = IDX_W'(k_reg);
                    mem_wr_data = mem_rd_data;
                    mem_rd_addr = IDX_W'(k_reg + CNT_W'(2));
                    k_next      = k_reg + CNT_W'(1);
                end
            end
            art_pkg::ST_DONE: begin
                // hold the response until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: status_reg, result_address: addr_reg,
                                     region_count: art_pkg::COUNT_W'(count_reg)};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= art_pkg::ST_IDLE;
            count_reg   <= CNT_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        prev_reg   <= prev_next;
        ins_reg    <= ins_next;
        cur_reg    <= cur_next;
        k_reg      <= k_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
        m_data_reg <= m_data_next;
    end

endmodule
`default_nettype wire

@@ rtl/address_region_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// address_region_table: first-fit table of used address regions
// Usage:
//   s_* carries one request (allocate, free or add); m_* returns one response
//   per request with status, allocated address and the entry count.
//   cfg_wr_en/cfg_index/cfg_wr_data write region_base and region_limit;
//   write them only while no request is in flight. A boot_flags write is
//   ignored: reset builds the boot entry from the reset values.
//   Requests are handled one at a time. The scan reads one entry per cycle
//   from the entry memory; an insert or delete then moves one entry per
//   cycle through its single write port, an insert working down from the
//   top entry and a delete working up from where the scan stopped. The
//   response is then loaded into the output register.
//   After reset the table holds one empty boot entry at the base reset value;
//   no clearing pass is needed. A stalled m_ready holds the response in the
//   output register; the next request is taken once the block returns idle.
// ----------------------------------------------------------------------------
module address_region_table #(
    parameter int MAX_REGIONS = 64
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_wr_en,
    input  wire [1:0]                      cfg_index,
    input  wire [art_pkg::ADDR_W-1:0]      cfg_wr_data,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  art_pkg::req_t                  s_data,
    output logic                           m_valid,
    input  wire                            m_ready,
    output art_pkg::rsp_t                  m_data
);

    localparam int IDX_W = $clog2(MAX_REGIONS);

    logic [art_pkg::ADDR_W-1:0] base_reg;
    logic [art_pkg::ADDR_W-1:0] limit_reg;

    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    art_pkg::entry_t   mem_wr_data;
    logic [IDX_W-1:0]  mem_rd_addr;
    art_pkg::entry_t   mem_rd_data;

    // configuration registers; boot flags are not stored, the boot entry uses the reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= art_pkg::BASE_RESET;
            limit_reg <= art_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == art_pkg::CFG_REGION_BASE) begin
                base_reg <= cfg_wr_data;
            end
            if (cfg_index == art_pkg::CFG_REGION_LIMIT) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    art_mem #(
        .DEPTH(MAX_REGIONS)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    art_ctrl #(
        .MAX_REGIONS(MAX_REGIONS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .region_base  (base_reg),
        .region_limit (limit_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

`ifndef SYNTHESIS
    // one request at a time: accepting a request closes the input
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    // a nonzero address is only returned by a successful allocate
    a_addr_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.result_address != '0)) |-> (m_data.status == art_pkg::STATUS_OK))
        else $error("address returned with failing status");

    // the entry count never exceeds the table size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((MAX_REGIONS > 127) || (int'(m_data.region_count) <= MAX_REGIONS)))
        else $error("entry count above table size");
`endif

endmodule
`default_nettype wire

@@ tb/address_region_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_region_table_tb: self-checking bench for the address region table
// Drives allocate, free and add requests through valid/ready with random
// idling, keeps its own sorted region table to predict every response, and
// compares responses field by field. Runs several base/limit settings.
// ----------------------------------------------------------------------------
module address_region_table_tb;

    localparam int DEPTH     = 64;
    localparam int WATCHDOG  = 6000;
    localparam int SETTLE    = 2 * DEPTH + 10;
    localparam int AW        = art_pkg::ADDR_W;
    localparam int FW        = art_pkg::FLAGS_W;
    localparam int CW        = art_pkg::COUNT_W;

    typedef struct {
        art_pkg::req_t rq;
        bit            typed;
        art_pkg::rsp_t rs;
    } dir_row_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [1:0]          cfg_index;
    logic [AW-1:0]       cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    art_pkg::req_t       s_data;
    logic                m_valid;
    logic                m_ready;
    art_pkg::rsp_t       m_data;

    // predicted table and registers
    logic [AW-1:0]       tbl_start [DEPTH];
    logic [AW-1:0]       tbl_end   [DEPTH];
    logic [FW-1:0]       tbl_flags [DEPTH];
    int                  tbl_count;
    logic [AW-1:0]       cfg_base;
    logic [AW-1:0]       cfg_limit;

    art_pkg::rsp_t       pending_rsp[$];
    dir_row_t            dir_rows[$];
    int                  errors;
    int                  idle_cnt;
    bit                  quiet;
    bit                  hold_off_req;

    address_region_table uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // open a slot at pos, shifting entries up
    task automatic open_slot(input int pos);
        for (int k = tbl_count; k > pos; k--) begin
            tbl_start[k] = tbl_start[k-1];
            tbl_end[k]   = tbl_end[k-1];
            tbl_flags[k] = tbl_flags[k-1];
        end
        tbl_count++;
    endtask

    // close the slot at pos, shifting entries down
    task automatic close_slot(input int pos);
        for (int k = pos; k + 1 < tbl_count; k++) begin
            tbl_start[k] = tbl_start[k+1];
            tbl_end[k]   = tbl_end[k+1];
            tbl_flags[k] = tbl_flags[k+1];
        end
        tbl_count--;
    endtask

    // apply one request to the predicted table and return its response
    task automatic region_update(input art_pkg::req_t rq, output art_pkg::rsp_t rs);
        logic [AW:0]       sum;
        logic [AW-1:0]     gs, ge;
        logic [1:0]        st;
        logic [AW-1:0]     addr;
        int                i;
        bit                hit;
        st   = art_pkg::STATUS_INVALID;
        addr = '0;
        hit  = 1'b0;
        case (rq.req_type)
            art_pkg::REQ_ALLOC: begin
                st = art_pkg::STATUS_NOGAP;
                for (i = 0; i <= tbl_count && !hit; i++) begin
                    gs  = (i > 0) ? tbl_end[i-1] : cfg_base;
                    ge  = (i < tbl_count) ? tbl_start[i] : cfg_limit;
                    sum = {1'b0, gs} + {1'b0, rq.alloc_size};
                    if (!sum[AW] && sum[AW-1:0] < ge && gs >= cfg_base
                            && sum[AW-1:0] < cfg_limit) begin
                        hit = 1'b1;
                        if (i > 0 && tbl_flags[i-1] == rq.region_flags) begin
                            tbl_end[i-1] = sum[AW-1:0];
                            st = art_pkg::STATUS_OK;
                            addr = gs;
                        end else if (tbl_count >= DEPTH) begin
                            st = art_pkg::STATUS_FULL;
                        end else begin
                            open_slot(i);
                            tbl_start[i] = gs;
                            tbl_end[i]   = sum[AW-1:0];
                            tbl_flags[i] = rq.region_flags;
                            st = art_pkg::STATUS_OK;
                            addr = gs;
                        end
                    end
                end
            end
            art_pkg::REQ_FREE: begin
                if (rq.range_start < rq.range_end) begin
                    for (i = 0; i < tbl_count && !hit; i++) begin
                        if (rq.range_start >= tbl_start[i] && rq.range_end <= tbl_end[i])
                            hit = 1'b1;
                    end
                    i--;
                    if (hit) begin
                        st = art_pkg::STATUS_OK;
                        if (rq.range_start == tbl_start[i] && rq.range_end == tbl_end[i]) begin
                            close_slot(i);
                        end else if (rq.range_start == tbl_start[i]) begin
                            tbl_start[i] = rq.range_end;
                        end else if (rq.range_end == tbl_end[i]) begin
                            tbl_end[i] = rq.range_start;
                        end else if (tbl_count >= DEPTH) begin
                            st = art_pkg::STATUS_FULL;
                        end else begin
                            open_slot(i + 1);
                            tbl_start[i+1] = rq.range_end;
                            tbl_end[i+1]   = tbl_end[i];
                            tbl_flags[i+1] = tbl_flags[i];
                            tbl_end[i]     = rq.range_start;
                        end
                    end
                end
            end
            art_pkg::REQ_ADD: begin
                if (rq.range_start < rq.range_end) begin
                    for (i = 0; i <= tbl_count && !hit; i++) begin
                        if ((i == 0 || tbl_end[i-1] <= rq.range_start) &&
                                (i == tbl_count || tbl_start[i] >= rq.range_end))
                            hit = 1'b1;
                    end
                    i--;
                    if (hit) begin
                        if (tbl_count >= DEPTH) begin
                            st = art_pkg::STATUS_FULL;
                        end else begin
                            open_slot(i);
                            tbl_start[i] = rq.range_start;
                            tbl_end[i]   = rq.range_end;
                            tbl_flags[i] = rq.region_flags;
                            st = art_pkg::STATUS_OK;
                        end
                    end
                end
            end
            default: st = art_pkg::STATUS_INVALID;
        endcase
        rs.status         = st;
        rs.result_address = addr;
        rs.region_count   = tbl_count[CW-1:0];
    endtask

    // offer one request, hold it until taken, then idle at random
    task automatic send_request(input art_pkg::req_t rq, input bit typed,
                                input art_pkg::rsp_t typed_rsp);
        art_pkg::rsp_t rs;
        s_data  <= rq;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        region_update(rq, rs);
        pending_rsp.push_back(typed ? typed_rsp : rs);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [AW-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
        if (idx == art_pkg::CFG_REGION_BASE)
            cfg_base = val;
        else if (idx == art_pkg::CFG_REGION_LIMIT)
            cfg_limit = val;
    endtask

    // drop valid and wait until every response is back and the block is idle
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // random well-formed request with occasional noise
    function automatic art_pkg::req_t random_request(input int alloc_pct);
        art_pkg::req_t     rq;
        int                pick, j;
        logic [AW-1:0]     lo, hi, w;
        rq.req_type     = art_pkg::REQ_ALLOC;
        rq.range_start  = AW'({$urandom, $urandom});
        rq.range_end    = AW'({$urandom, $urandom});
        rq.alloc_size   = AW'($urandom_range(0, 'h3000));
        rq.region_flags = FW'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        j    = (tbl_count > 0) ? int'($urandom_range(0, tbl_count - 1)) : 0;
        if (pick < 5) begin
            // noise: any field value, unknown type included
            rq.req_type     = 2'($urandom_range(0, 3));
            rq.alloc_size   = AW'({$urandom, $urandom});
            rq.region_flags = FW'($urandom);
        end else if (pick < alloc_pct) begin
            if ($urandom_range(0, 9) == 0)
                rq.alloc_size = AW'({$urandom, $urandom}) >> $urandom_range(0, 47);
        end else if (pick < alloc_pct + (100 - alloc_pct) / 2 && tbl_count > 0) begin
            rq.req_type = art_pkg::REQ_FREE;
            lo = tbl_start[j];
            hi = tbl_end[j];
            w  = hi - lo;
            case ($urandom_range(0, 3))
                0: begin rq.range_start = lo; rq.range_end = hi; end
                1: begin rq.range_start = lo; rq.range_end = lo + (w >> 1); end
                2: begin rq.range_start = lo + (w >> 1); rq.range_end = hi; end
                default: begin
                    rq.range_start = lo + (w >> 2);
                    rq.range_end   = hi - (w >> 2);
                end
            endcase
        end else begin
            rq.req_type     = art_pkg::REQ_ADD;
            rq.region_flags = FW'($urandom);
            lo = tbl_end[j];
            hi = (j + 1 < tbl_count) ? tbl_start[j+1] : 48'hFFFF_FFFF_FFFF;
            rq.range_start = lo + AW'($urandom_range(0, 'h100));
            rq.range_end   = rq.range_start + AW'($urandom_range(0, 'h800));
            if (hi < rq.range_end && $urandom_range(0, 1))
                rq.range_end = hi;
        end
        return rq;
    endfunction

    function automatic dir_row_t mk_row(input logic [1:0] ty, input logic [47:0] s,
                                        input logic [47:0] e, input logic [47:0] sz,
                                        input logic [7:0] fl, input bit typed,
                                        input logic [1:0] st, input logic [47:0] ad,
                                        input logic [6:0] cnt);
        dir_row_t r;
        r.rq    = '{req_type: ty, range_start: s, range_end: e, alloc_size: sz,
                    region_flags: fl};
        r.typed = typed;
        r.rs    = '{status: st, result_address: ad, region_count: cnt};
        return r;
    endfunction

    // compare each response with the oldest prediction
    always @(posedge aclk) begin
        art_pkg::rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response %p", $time, m_data);
                errors++;
            end else begin
                want = pending_rsp.pop_front();
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status,
                             m_data.status);
                    errors++;
                end
                if (m_data.result_address !== want.result_address) begin
                    $display("%0t: result_address expected %h got %h", $time,
                             want.result_address, m_data.result_address);
                    errors++;
                end
                if (m_data.region_count !== want.region_count) begin
                    $display("%0t: region_count expected %0d got %0d", $time,
                             want.region_count, m_data.region_count);
                    errors++;
                end
            end
        end
    end

    // watchdog: count cycles with no request or response moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WATCHDOG) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // response side: random stalls, one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    initial begin
        errors       = 0;
        idle_cnt     = 0;
        quiet        = 1'b0;
        hold_off_req = 1'b0;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = art_pkg::CFG_REGION_BASE;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_base     = art_pkg::BASE_RESET;
        cfg_limit    = art_pkg::LIMIT_RESET;
        tbl_start[0] = art_pkg::BASE_RESET;
        tbl_end[0]   = art_pkg::BASE_RESET;
        tbl_flags[0] = art_pkg::FLAGS_RESET;
        tbl_count    = 1;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: boot entry growth, errors, extremes, every request kind
        dir_rows.push_back(mk_row(art_pkg::REQ_ALLOC, 0, 0, 48'h1000, 8'h00, 1,
                                  art_pkg::STATUS_OK, 48'h40_0000, 7'd1));
        dir_rows.push_back(mk_row(art_pkg::REQ_FREE, 48'h5000, 48'h5000, 0, 0, 1,
                                  art_pkg::STATUS_INVALID, 0, 7'd1));
        dir_rows.push_back(mk_row(art_pkg::REQ_ADD, 48'hFFFF_FFFF_FFFF, 48'h0, 0, 0, 1,
                                  art_pkg::STATUS_INVALID, 0, 7'd1));
        dir_rows.push_back(mk_row(2'd3, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                                  48'hFFFF_FFFF_FFFF, 8'hFF, 1,
                                  art_pkg::STATUS_INVALID, 0, 7'd1));
        dir_rows.push_back(mk_row(art_pkg::REQ_ALLOC, 0, 0, 48'hFFFF_FFFF_FFFF, 8'h00, 1,
                                  art_pkg::STATUS_NOGAP, 0, 7'd1));
        dir_rows.push_back(mk_row(art_pkg::REQ_FREE, 48'h1, 48'h2, 0, 0, 1,
                                  art_pkg::STATUS_INVALID, 0, 7'd1));
        dir_rows.push_back(mk_row(art_pkg::REQ_ADD, 48'h0, 48'h1000, 0, 8'h5a, 1,
                                  art_pkg::STATUS_OK, 0, 7'd2));
        dir_rows.push_back(mk_row(art_pkg::REQ_ALLOC, 0, 0, 48'h0, 8'h07, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(art_pkg::REQ_ALLOC, 0, 0, 48'h0, 8'h00, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(art_pkg::REQ_ALLOC, 0, 0, 48'h800, 8'hFF, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(art_pkg::REQ_FREE, 48'h400100, 48'h400200, 0, 0,
                                  0, 0, 0, 0));
        dir_rows.push_back(mk_row(art_pkg::REQ_FREE, 48'h400000, 48'h400080, 0, 0,
                                  0, 0, 0, 0));
        dir_rows.push_back(mk_row(art_pkg::REQ_FREE, 48'h400F00, 48'h401000, 0, 0,
                                  0, 0, 0, 0));
        dir_rows.push_back(mk_row(art_pkg::REQ_FREE, 48'h0, 48'h1000, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(art_pkg::REQ_ADD, 48'hFFFF_FFFF_FFF0, 48'hFFFF_FFFF_FFFF,
                                  0, 8'hFF, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(art_pkg::REQ_ADD, 48'hFFFF_FFFF_FFF8, 48'hFFFF_FFFF_FFFF,
                                  0, 8'h01, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(art_pkg::REQ_FREE, 48'hFFFF_FFFF_FFF0, 48'hFFFF_FFFF_FFFF,
                                  0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(art_pkg::REQ_ALLOC, 0, 0, 48'h7FFF_FFFF_FFFF, 8'h00,
                                  0, 0, 0, 0));
        foreach (dir_rows[n])
            send_request(dir_rows[n].rq, dir_rows[n].typed, dir_rows[n].rs);
        drain();

        // random phases across base/limit settings, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin
                    write_reg(art_pkg::CFG_REGION_BASE, 48'h0);
                    write_reg(art_pkg::CFG_REGION_LIMIT, 48'hFFFF_FFFF_FFFF);
                    write_reg(art_pkg::CFG_BOOT_FLAGS, 48'hFF);
                end
                2: begin
                    write_reg(art_pkg::CFG_REGION_BASE, 48'h1000);
                    write_reg(art_pkg::CFG_REGION_LIMIT, 48'h40_8000);
                    write_reg(art_pkg::CFG_BOOT_FLAGS, 48'h00);
                end
                3: begin
                    write_reg(art_pkg::CFG_REGION_BASE, 48'hFFFF_FFFF_FFFF);
                    write_reg(art_pkg::CFG_REGION_LIMIT, 48'h0);
                end
                4: begin
                    write_reg(art_pkg::CFG_REGION_BASE, 48'h0);
                    write_reg(art_pkg::CFG_REGION_LIMIT, 48'h8000_0000_0000);
                    quiet = 1'b1;
                end
                default: ;
            endcase
            for (int n = 0; n < 250; n++) begin
                if (ph == 1 && n == 40)
                    hold_off_req = 1'b1;
                send_request(random_request(ph == 4 ? 40 : 65), 1'b0, '0);
            end
            drain();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
